// ===== hdl/zdf_pkg.sv =====
// Package for the four-pole zero-delay-feedback ladder lowpass.
// Holds widths, register and step codes, and the control types shared by
// zdf_mac and zdf_ladder_lowpass_4pole.
package zdf_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int STATE_BITS_DEF  = 32;
   localparam int OPER_BITS_DEF   = 40;

   localparam int CHUNK_BITS     = 20;
   localparam int CHUNK_IDX_BITS = 2;

   localparam int COEF_BITS = 19;
   localparam int GAIN_BITS = 18;
   localparam int FB_BITS   = 19;
   localparam int NORM_BITS = 18;

   localparam logic [COEF_BITS-1:0] GAIN_ONE = COEF_BITS'(1 << GAIN_BITS);

   localparam int SHIFT_GAIN = 18;
   localparam int SHIFT_FB   = 16;
   localparam int SHIFT_NORM = 17;

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STAGE_GAIN    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FEEDBACK_K    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FEEDBACK_NORM = 2'd2;

   localparam int OP_BITS = 4;
   localparam logic [OP_BITS-1:0] OP_STAGE_MEM_FIRST = 4'd0;
   localparam logic [OP_BITS-1:0] OP_FEEDBACK        = 4'd4;
   localparam logic [OP_BITS-1:0] OP_NORM            = 4'd5;
   localparam logic [OP_BITS-1:0] OP_STAGE_OUT_FIRST = 4'd6;
   localparam logic [OP_BITS-1:0] OP_LAST            = 4'd9;

   typedef enum logic [1:0] {
      RSH_GAIN,
      RSH_FB,
      RSH_NORM
   } rsh_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FIN,
      ST_UPD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                      en;
      logic                      first;
      logic [CHUNK_IDX_BITS-1:0] chunk;
      rsh_type                   rsh;
   } mac_ctl_type;

endpackage

// ===== hdl/zdf_mac.sv =====
// Shared multiply-accumulate: one chunk times a coefficient per cycle while ctl.en.
// Gives round-half-up of operand*coef/2^shift. Depends on zdf_pkg.
module zdf_mac #(
   parameter int OPER_BITS = zdf_pkg::OPER_BITS_DEF
) (
   input  logic                               clock,
   input  zdf_pkg::mac_ctl_type               ctl,
   input  logic signed [OPER_BITS-1:0]        op_a,
   input  logic [zdf_pkg::COEF_BITS-1:0]      op_b,
   output logic signed [OPER_BITS-1:0]        result
);

   localparam int CB     = zdf_pkg::CHUNK_BITS;
   localparam int NCHUNK = (OPER_BITS + zdf_pkg::CHUNK_BITS - 1) / zdf_pkg::CHUNK_BITS;
   localparam int EXT_W  = NCHUNK * CB;
   localparam int ACC_W  = OPER_BITS + zdf_pkg::COEF_BITS + 2;
   localparam int PROD_W = CB + zdf_pkg::COEF_BITS + 2;

   logic signed [EXT_W-1:0]             a_ext;
   logic [CB-1:0]                       a_chunk;
   logic                                last_chunk;
   logic signed [CB:0]                  mul_x;
   logic signed [zdf_pkg::COEF_BITS:0]  mul_y;
   logic signed [PROD_W-1:0]            prod;
   logic signed [ACC_W-1:0]             term;
   logic signed [ACC_W-1:0]             half;
   logic signed [ACC_W-1:0]             acc_shr;
   logic signed [ACC_W-1:0]             acc_in;
   logic signed [ACC_W-1:0]             acc_ff;

   assign a_ext      = EXT_W'(op_a);
   assign a_chunk    = a_ext[ctl.chunk * CB +: CB];
   assign last_chunk = (ctl.chunk == zdf_pkg::CHUNK_IDX_BITS'(NCHUNK - 1));
   assign mul_x      = last_chunk ? {a_chunk[CB-1], a_chunk} : {1'b0, a_chunk};
   assign mul_y      = {1'b0, op_b};
   assign prod       = mul_x * mul_y;
   assign term       = ACC_W'(prod) << (CB * ctl.chunk);

   always_comb begin
      case (ctl.rsh)
         zdf_pkg::RSH_FB: begin
            half    = ACC_W'(1) << (zdf_pkg::SHIFT_FB - 1);
            acc_shr = acc_ff >>> zdf_pkg::SHIFT_FB;
         end
         zdf_pkg::RSH_NORM: begin
            half    = ACC_W'(1) << (zdf_pkg::SHIFT_NORM - 1);
            acc_shr = acc_ff >>> zdf_pkg::SHIFT_NORM;
         end
         default: begin
            half    = ACC_W'(1) << (zdf_pkg::SHIFT_GAIN - 1);
            acc_shr = acc_ff >>> zdf_pkg::SHIFT_GAIN;
         end
      endcase
   end

   assign acc_in = (ctl.first ? half : acc_ff) + term;
   assign result = acc_shr[OPER_BITS-1:0];

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== hdl/zdf_ladder_lowpass_4pole.sv =====
// Four-pole zero-delay-feedback ladder lowpass, one sample per item.
// Each sample runs ST_MUL and ST_FIN per step, ST_UPD on stage outputs, then ST_OUT;
// req_stall blocks new items until then; one chunked MAC in zdf_mac does every step.
// Reset (synchronous): integrator states zero, registers to defaults, no item held.
// Depends on zdf_pkg and zdf_mac.
module zdf_ladder_lowpass_4pole #(
   parameter int SAMPLE_BITS = zdf_pkg::SAMPLE_BITS_DEF,
   parameter int STATE_BITS  = zdf_pkg::STATE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [zdf_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [zdf_pkg::COEF_BITS-1:0]         csr_data
);

   localparam int SB        = SAMPLE_BITS;
   localparam int S         = STATE_BITS;
   localparam int OPER_BITS = (S + 8 > SB + 3) ? S + 8 : SB + 3;
   localparam int NCHUNK    = (OPER_BITS + zdf_pkg::CHUNK_BITS - 1) / zdf_pkg::CHUNK_BITS;
   localparam int CW        = (S > SB) ? S : SB;

   localparam logic [zdf_pkg::CHUNK_IDX_BITS-1:0] LAST_CHUNK =
      zdf_pkg::CHUNK_IDX_BITS'(NCHUNK - 1);

   localparam logic signed [S-1:0]         ST_HI_S  = {1'b0, {(S-1){1'b1}}};
   localparam logic signed [S-1:0]         ST_LO_S  = {1'b1, {(S-1){1'b0}}};
   localparam logic signed [OPER_BITS-1:0] ST_HI_O  = OPER_BITS'(ST_HI_S);
   localparam logic signed [OPER_BITS-1:0] ST_LO_O  = OPER_BITS'(ST_LO_S);
   localparam logic signed [S+1:0]         ST_HI_U  = (S+2)'(ST_HI_S);
   localparam logic signed [S+1:0]         ST_LO_U  = (S+2)'(ST_LO_S);
   localparam logic signed [SB-1:0]        SMP_HI   = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0]        SMP_LO   = {1'b1, {(SB-1){1'b0}}};
   localparam logic signed [CW-1:0]        SMP_HI_C = CW'(SMP_HI);
   localparam logic signed [CW-1:0]        SMP_LO_C = CW'(SMP_LO);

   zdf_pkg::state_type                    state_ff, state_in;
   logic [zdf_pkg::GAIN_BITS-1:0]         gain_ff, gain_in;
   logic [zdf_pkg::FB_BITS-1:0]           k_ff, k_in;
   logic [zdf_pkg::NORM_BITS-1:0]         norm_ff, norm_in;
   logic signed [SB-1:0]                  x_ff, x_in;
   logic [zdf_pkg::OP_BITS-1:0]           op_ff, op_in;
   logic [zdf_pkg::CHUNK_IDX_BITS-1:0]    chunk_ff, chunk_in;
   logic signed [S+1:0]                   sum_ff, sum_in;
   logic signed [S-1:0]                   s_part_ff [4];
   logic signed [S-1:0]                   s_part_in [4];
   logic signed [S-1:0]                   integ_ff [4];
   logic signed [S-1:0]                   integ_in [4];
   logic signed [OPER_BITS-1:0]           d_ff, d_in;
   logic signed [S-1:0]                   v_ff, v_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]                  rsp_sample_ff, rsp_sample_in;

   zdf_pkg::mac_ctl_type                  mac_ctl;
   logic signed [OPER_BITS-1:0]           mac_a;
   logic [zdf_pkg::COEF_BITS-1:0]         mac_b;
   logic signed [OPER_BITS-1:0]           mac_res;
   logic [zdf_pkg::COEF_BITS-1:0]         one_minus_g;
   logic [zdf_pkg::OP_BITS-1:0]           op_rel;
   logic [1:0]                            stg;
   logic signed [S-1:0]                   s_new;
   logic signed [OPER_BITS-1:0]           fin_val;
   logic signed [S-1:0]                   fin_sat;
   logic signed [S+1:0]                   upd_val;
   logic signed [S-1:0]                   upd_sat;
   logic signed [CW-1:0]                  v_c;
   logic signed [SB-1:0]                  out_sat;

   assign req_stall      = (state_ff != zdf_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign csr_ready      = 1'b1;

   assign one_minus_g = zdf_pkg::GAIN_ONE - zdf_pkg::COEF_BITS'(gain_ff);
   assign op_rel      = op_ff - zdf_pkg::OP_STAGE_OUT_FIRST;
   assign stg         = (op_ff < zdf_pkg::OP_FEEDBACK) ? op_ff[1:0] : op_rel[1:0];

   always_comb begin
      mac_ctl.en    = (state_ff == zdf_pkg::ST_MUL);
      mac_ctl.first = (chunk_ff == '0);
      mac_ctl.chunk = chunk_ff;
      if (op_ff < zdf_pkg::OP_FEEDBACK) begin
         mac_ctl.rsh = zdf_pkg::RSH_GAIN;
         mac_a       = OPER_BITS'(integ_ff[stg]);
         mac_b       = one_minus_g;
      end else if (op_ff == zdf_pkg::OP_FEEDBACK) begin
         mac_ctl.rsh = zdf_pkg::RSH_FB;
         mac_a       = OPER_BITS'(sum_ff);
         mac_b       = k_ff;
      end else if (op_ff == zdf_pkg::OP_NORM) begin
         mac_ctl.rsh = zdf_pkg::RSH_NORM;
         mac_a       = d_ff;
         mac_b       = zdf_pkg::COEF_BITS'(norm_ff);
      end else begin
         mac_ctl.rsh = zdf_pkg::RSH_GAIN;
         mac_a       = OPER_BITS'(v_ff);
         mac_b       = zdf_pkg::COEF_BITS'(gain_ff);
      end
   end

   zdf_mac #(
      .OPER_BITS (OPER_BITS)
   ) u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .op_a   (mac_a),
      .op_b   (mac_b),
      .result (mac_res)
   );

   assign s_new   = mac_res[S-1:0];
   assign fin_val = (op_ff >= zdf_pkg::OP_STAGE_OUT_FIRST) ?
                    mac_res + OPER_BITS'(s_part_ff[stg]) : mac_res;
   assign fin_sat = (fin_val > ST_HI_O) ? ST_HI_S :
                    (fin_val < ST_LO_O) ? ST_LO_S : fin_val[S-1:0];
   assign upd_val = ((S+2)'(v_ff) <<< 1) - (S+2)'(integ_ff[stg]);
   assign upd_sat = (upd_val > ST_HI_U) ? ST_HI_S :
                    (upd_val < ST_LO_U) ? ST_LO_S : upd_val[S-1:0];
   assign v_c     = CW'(v_ff);
   assign out_sat = (v_c > SMP_HI_C) ? SMP_HI :
                    (v_c < SMP_LO_C) ? SMP_LO : v_c[SB-1:0];

   always_comb begin
      state_in      = state_ff;
      gain_in       = gain_ff;
      k_in          = k_ff;
      norm_in       = norm_ff;
      x_in          = x_ff;
      op_in         = op_ff;
      chunk_in      = chunk_ff;
      sum_in        = sum_ff;
      s_part_in     = s_part_ff;
      integ_in      = integ_ff;
      d_in          = d_ff;
      v_in          = v_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;

      if (csr_valid) begin
         case (csr_index)
            zdf_pkg::CSR_STAGE_GAIN:    gain_in = csr_data[zdf_pkg::GAIN_BITS-1:0];
            zdf_pkg::CSR_FEEDBACK_K:    k_in    = csr_data[zdf_pkg::FB_BITS-1:0];
            zdf_pkg::CSR_FEEDBACK_NORM: norm_in = csr_data[zdf_pkg::NORM_BITS-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         zdf_pkg::ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               op_in    = zdf_pkg::OP_STAGE_MEM_FIRST;
               chunk_in = '0;
               sum_in   = '0;
               state_in = zdf_pkg::ST_MUL;
            end
         end
         zdf_pkg::ST_MUL: begin
            if (chunk_ff == LAST_CHUNK) begin
               chunk_in = '0;
               state_in = zdf_pkg::ST_FIN;
            end else begin
               chunk_in = chunk_ff + zdf_pkg::CHUNK_IDX_BITS'(1);
            end
         end
         zdf_pkg::ST_FIN: begin
            if (op_ff < zdf_pkg::OP_FEEDBACK) begin
               s_part_in[stg] = s_new;
               sum_in         = sum_ff + (S+2)'(s_new);
               op_in          = op_ff + zdf_pkg::OP_BITS'(1);
               state_in       = zdf_pkg::ST_MUL;
            end else if (op_ff == zdf_pkg::OP_FEEDBACK) begin
               d_in     = OPER_BITS'(x_ff) - mac_res;
               op_in    = op_ff + zdf_pkg::OP_BITS'(1);
               state_in = zdf_pkg::ST_MUL;
            end else if (op_ff == zdf_pkg::OP_NORM) begin
               v_in     = fin_sat;
               op_in    = op_ff + zdf_pkg::OP_BITS'(1);
               state_in = zdf_pkg::ST_MUL;
            end else begin
               v_in     = fin_sat;
               state_in = zdf_pkg::ST_UPD;
            end
         end
         zdf_pkg::ST_UPD: begin
            integ_in[stg] = upd_sat;
            if (op_ff == zdf_pkg::OP_LAST) begin
               state_in = zdf_pkg::ST_OUT;
            end else begin
               op_in    = op_ff + zdf_pkg::OP_BITS'(1);
               state_in = zdf_pkg::ST_MUL;
            end
         end
         zdf_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = out_sat;
               state_in      = zdf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = zdf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= zdf_pkg::ST_IDLE;
         gain_ff      <= zdf_pkg::GAIN_BITS'(131072);
         k_ff         <= '0;
         norm_ff      <= zdf_pkg::NORM_BITS'(131072);
         integ_ff     <= '{default: '0};
         rsp_valid_ff <= 1'b0;
         op_ff        <= '0;
         chunk_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         k_ff         <= k_in;
         norm_ff      <= norm_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         chunk_ff     <= chunk_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      sum_ff        <= sum_in;
      s_part_ff     <= s_part_in;
      d_ff          <= d_in;
      v_ff          <= v_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   a_start_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == zdf_pkg::ST_MUL &&
         op_ff == zdf_pkg::OP_STAGE_MEM_FIRST && chunk_ff == '0)
      else $error("item accepted without restarting the step sequence");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == zdf_pkg::ST_OUT)
      else $error("result raised outside the output step");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == zdf_pkg::ST_OUT && !(rsp_valid_ff && rsp_stall) |=>
         rsp_valid_ff && state_ff == zdf_pkg::ST_IDLE)
      else $error("free output register not loaded");

   a_upd_op: assert property (@(posedge clock) disable iff (reset)
      state_ff == zdf_pkg::ST_UPD |->
         op_ff >= zdf_pkg::OP_STAGE_OUT_FIRST && op_ff <= zdf_pkg::OP_LAST)
      else $error("state update on a step that is not a stage output");

endmodule
